// ===== hw/rtl/lz_gamma_stream_decompressor_assert.svh =====
// assertion macros shared by the decompressor rtl
// no dependencies; included by the top level
`ifndef LZ_GAMMA_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ_GAMMA_STREAM_DECOMPRESSOR_ASSERT_SVH

// antecedent implies consequent in the same cycle, disabled in reset
`define LZG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition never holds outside reset
`define LZG_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/lzg_pkg.sv =====
// shared types and constants of the lz gamma stream decompressor
// no dependencies
`timescale 1ns / 1ps

package lzg_pkg;

  localparam int WIN_DEPTH = 32768;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int END_CODE  = 256;
  localparam int MAX_BURST = 64;
  localparam int RES_CAP   = 64;
  localparam int CNT_W     = 17;
  localparam int BURST_W   = 7;
  localparam int RES_W     = 7;
  localparam int GAMMA_LIM = 65535;

  typedef enum logic [3:0] {
    PH_LIT_STOP, PH_LIT_DATA, PH_LITERALS, PH_AFTER_LIT, PH_CMD,
    PH_OFS_STOP, PH_OFS_DATA, PH_OFS_LOW, PH_LEN_STOP, PH_LEN_DATA,
    PH_REP_STOP, PH_REP_DATA, PH_COPY, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_ERR  = 2'd2
  } rstat_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_START, CMD_BIT, CMD_TO_CMD, CMD_RD_FIRST, CMD_RD,
    CMD_WR, CMD_FAIL, CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic term;
    logic copy;
    logic brk;
    logic ended;
    logic copy_nz;
    logic res_ok;
    logic burst_ok;
    logic skip;
    logic hold_v;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/lzg_datapath.sv =====
// decode registers, history window, result hold and output register
// depends on lzg_pkg
`timescale 1ns / 1ps

module lzg_datapath
  import lzg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_action,
  input  logic [7:0]        in_byte,
  input  logic              in_last_byte,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_total_length,
  output logic              out_copy_pending,
  output logic              out_last
);

  phase_t             phase_r, phase_nxt;
  logic [7:0]         bitbuf_r, bitbuf_nxt;
  logic [3:0]         bits_r, bits_nxt;
  logic [CNT_W-1:0]   gamma_r, gamma_nxt;
  logic [CNT_W-1:0]   lit_r, lit_nxt;
  logic [CNT_W-1:0]   lastoff_r, lastoff_nxt;
  logic [CNT_W-1:0]   copy_r, copy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [8:0]         pend_r, pend_nxt;
  logic [CNT_W-1:0]   max_r;
  logic               ended_r, ended_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic               outv_r, outv_nxt;

  logic [7:0]         hold_byte_r;
  logic [1:0]         hold_st_r;
  logic [CNT_W-1:0]   hold_tot_r;
  logic               hold_pend_r;

  logic [7:0]         ob_r;
  logic [1:0]         ost_r;
  logic [CNT_W-1:0]   otot_r;
  logic               opend_r;
  logic               olast_r;

  logic [7:0]         mem [WIN_DEPTH];
  logic [7:0]         rd_data;
  logic               mem_we;
  logic [7:0]         mem_wd;
  logic               rd_en;
  logic [WIN_AW-1:0]  rd_addr;
  logic [CNT_W-1:0]   src_diff;

  logic               emit_en;
  logic [7:0]         em_byte;
  logic [1:0]         em_st;
  logic [CNT_W-1:0]   em_tot;
  logic               em_pend;
  logic               push;
  logic               push_last;

  assign src_diff = cnt_r - lastoff_r;
  assign rd_addr  = src_diff[WIN_AW-1:0];

  always_comb begin
    logic             b;
    logic [CNT_W:0]   len;
    logic [CNT_W+1:0] sum;
    logic             src_bad;
    logic [RES_W-1:0] res_base;
    phase_nxt   = phase_r;
    bitbuf_nxt  = bitbuf_r;
    bits_nxt    = bits_r;
    gamma_nxt   = gamma_r;
    lit_nxt     = lit_r;
    lastoff_nxt = lastoff_r;
    copy_nxt    = copy_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    ended_nxt   = ended_r;
    burst_nxt   = burst_r;
    emit_en     = 1'b0;
    em_byte     = 8'd0;
    em_st       = ST_DATA;
    em_tot      = '0;
    em_pend     = 1'b0;
    mem_we      = 1'b0;
    mem_wd      = in_byte;
    rd_en       = 1'b0;
    b           = bitbuf_r[7];
    len         = '0;
    sum         = '0;
    src_bad     = 1'b0;
    res_base    = (cmd == CMD_START) ? '0 : res_r;

    case (cmd)
      CMD_START: begin
        if (phase_r == PH_DONE) begin
          emit_en = 1'b1;
          em_st   = ST_END;
          em_tot  = cnt_r;
        end else if (phase_r == PH_ERROR) begin
          emit_en = 1'b1;
          em_st   = ST_ERR;
        end else if (in_action) begin
          // continue: nothing to set up here
        end else if (phase_r == PH_COPY) begin
          phase_nxt = PH_ERROR;
          emit_en   = 1'b1;
          em_st     = ST_ERR;
        end else begin
          if (in_last_byte) ended_nxt = 1'b1;
          if (phase_r == PH_LITERALS) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            emit_en = 1'b1;
            em_byte = in_byte;
            lit_nxt = lit_r - 1'b1;
            if (lit_r == CNT_W'(1)) phase_nxt = PH_AFTER_LIT;
          end else if (phase_r == PH_OFS_LOW) begin
            lastoff_nxt = {pend_r, ~in_byte[7:1]} + 1'b1;
            if (in_byte[0]) begin
              len     = (CNT_W+1)'(2);
              src_bad = (lastoff_nxt > cnt_r) || (lastoff_nxt > CNT_W'(WIN_DEPTH));
              sum     = {2'b0, cnt_r} + {1'b0, len};
              if (src_bad || sum > {2'b0, max_r}) begin
                phase_nxt = PH_ERROR;
                emit_en   = 1'b1;
                em_st     = ST_ERR;
              end else begin
                copy_nxt  = len[CNT_W-1:0];
                phase_nxt = PH_COPY;
              end
            end else begin
              gamma_nxt = CNT_W'(1);
              phase_nxt = PH_LEN_DATA;
            end
          end else begin
            bitbuf_nxt = in_byte;
            bits_nxt   = 4'd8;
          end
        end
      end
      CMD_BIT: begin
        bitbuf_nxt = {bitbuf_r[6:0], 1'b0};
        bits_nxt   = bits_r - 1'b1;
        case (phase_r)
          PH_LIT_STOP: begin
            if (b) begin
              sum = {2'b0, cnt_r} + {2'b0, gamma_r};
              if (sum > {2'b0, max_r}) begin
                phase_nxt = PH_ERROR;
                emit_en   = 1'b1;
                em_st     = ST_ERR;
              end else begin
                lit_nxt   = gamma_r;
                phase_nxt = PH_LITERALS;
              end
            end else begin
              phase_nxt = PH_LIT_DATA;
            end
          end
          PH_LIT_DATA, PH_OFS_DATA, PH_LEN_DATA, PH_REP_DATA: begin
            if (gamma_r > CNT_W'(GAMMA_LIM)) begin
              phase_nxt = PH_ERROR;
              emit_en   = 1'b1;
              em_st     = ST_ERR;
            end else begin
              gamma_nxt = {gamma_r[CNT_W-2:0], b};
              case (phase_r)
                PH_LIT_DATA: phase_nxt = PH_LIT_STOP;
                PH_OFS_DATA: phase_nxt = PH_OFS_STOP;
                PH_LEN_DATA: phase_nxt = PH_LEN_STOP;
                default:     phase_nxt = PH_REP_STOP;
              endcase
            end
          end
          PH_AFTER_LIT: begin
            gamma_nxt = CNT_W'(1);
            phase_nxt = b ? PH_OFS_STOP : PH_REP_STOP;
          end
          PH_CMD: begin
            gamma_nxt = CNT_W'(1);
            phase_nxt = b ? PH_OFS_STOP : PH_LIT_STOP;
          end
          PH_OFS_STOP: begin
            if (b) begin
              if (gamma_r == CNT_W'(END_CODE)) begin
                phase_nxt = PH_DONE;
                emit_en   = 1'b1;
                em_st     = ST_END;
                em_tot    = cnt_r;
              end else if (gamma_r > CNT_W'(END_CODE)) begin
                phase_nxt = PH_ERROR;
                emit_en   = 1'b1;
                em_st     = ST_ERR;
              end else begin
                pend_nxt  = 9'(gamma_r - 1'b1);
                phase_nxt = PH_OFS_LOW;
              end
            end else begin
              phase_nxt = PH_OFS_DATA;
            end
          end
          PH_LEN_STOP, PH_REP_STOP: begin
            if (b) begin
              len     = (phase_r == PH_LEN_STOP) ? ({1'b0, gamma_r} + 1'b1)
                                                 : {1'b0, gamma_r};
              src_bad = (lastoff_r > cnt_r) || (lastoff_r > CNT_W'(WIN_DEPTH));
              sum     = {2'b0, cnt_r} + {1'b0, len};
              if (src_bad || sum > {2'b0, max_r}) begin
                phase_nxt = PH_ERROR;
                emit_en   = 1'b1;
                em_st     = ST_ERR;
              end else begin
                copy_nxt  = len[CNT_W-1:0];
                phase_nxt = PH_COPY;
              end
            end else begin
              phase_nxt = (phase_r == PH_LEN_STOP) ? PH_LEN_DATA : PH_REP_DATA;
            end
          end
          default: ;
        endcase
      end
      CMD_TO_CMD: phase_nxt = PH_CMD;
      CMD_RD_FIRST: begin
        rd_en     = 1'b1;
        burst_nxt = '0;
      end
      CMD_RD: rd_en = 1'b1;
      CMD_WR: begin
        mem_we    = 1'b1;
        mem_wd    = rd_data;
        cnt_nxt   = cnt_r + 1'b1;
        copy_nxt  = copy_r - 1'b1;
        burst_nxt = burst_r + 1'b1;
        emit_en   = 1'b1;
        em_byte   = rd_data;
        em_pend   = (copy_r != CNT_W'(1));
      end
      CMD_FAIL: begin
        phase_nxt = PH_ERROR;
        emit_en   = 1'b1;
        em_st     = ST_ERR;
      end
      default: ;
    endcase

    res_nxt    = res_base;
    hold_v_nxt = hold_v_r;
    push       = 1'b0;
    push_last  = 1'b0;
    outv_nxt   = outv_r && !out_ready;
    if (emit_en && res_base < RES_W'(RES_CAP)) begin
      res_nxt    = res_base + 1'b1;
      hold_v_nxt = 1'b1;
      push       = hold_v_r;
    end else if (cmd == CMD_FINISH && hold_v_r) begin
      push       = 1'b1;
      push_last  = 1'b1;
      hold_v_nxt = 1'b0;
    end
    if (push) outv_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LIT_STOP;
      bitbuf_r  <= '0;
      bits_r    <= '0;
      gamma_r   <= CNT_W'(1);
      lit_r     <= '0;
      lastoff_r <= CNT_W'(1);
      copy_r    <= '0;
      cnt_r     <= '0;
      pend_r    <= '0;
      max_r     <= CNT_W'(65536);
      ended_r   <= 1'b0;
      res_r     <= '0;
      burst_r   <= '0;
      hold_v_r  <= 1'b0;
      outv_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bitbuf_r  <= bitbuf_nxt;
      bits_r    <= bits_nxt;
      gamma_r   <= gamma_nxt;
      lit_r     <= lit_nxt;
      lastoff_r <= lastoff_nxt;
      copy_r    <= copy_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      ended_r   <= ended_nxt;
      res_r     <= res_nxt;
      burst_r   <= burst_nxt;
      hold_v_r  <= hold_v_nxt;
      outv_r    <= outv_nxt;
      if (cfg_we) max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      hold_byte_r <= em_byte;
      hold_st_r   <= em_st;
      hold_tot_r  <= em_tot;
      hold_pend_r <= em_pend;
    end
    if (push) begin
      ob_r    <= hold_byte_r;
      ost_r   <= hold_st_r;
      otot_r  <= hold_tot_r;
      opend_r <= hold_pend_r;
      olast_r <= push_last;
    end
  end

  // history window, write at the output count, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[WIN_AW-1:0]] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign sts.term     = (phase_r == PH_DONE) || (phase_r == PH_ERROR);
  assign sts.copy     = (phase_r == PH_COPY);
  assign sts.brk      = (phase_r == PH_LITERALS) || (phase_r == PH_OFS_LOW) ||
                        (bits_r == 4'd0);
  assign sts.ended    = ended_r;
  assign sts.copy_nz  = (copy_r != '0);
  assign sts.res_ok   = (res_r < RES_W'(RES_CAP - 1));
  assign sts.burst_ok = (burst_r < BURST_W'(MAX_BURST));
  assign sts.skip     = in_action && (phase_r != PH_COPY) && (phase_r != PH_DONE) &&
                        (phase_r != PH_ERROR);
  assign sts.hold_v   = hold_v_r;
  assign sts.out_free = !outv_r || out_ready;

  assign out_valid        = outv_r;
  assign out_byte         = ob_r;
  assign out_status       = ost_r;
  assign out_total_length = otot_r;
  assign out_copy_pending = opend_r;
  assign out_last         = olast_r;

endmodule

// ===== hw/rtl/lzg_ctrl.sv =====
// sequencer: walks the bit loop, copy bursts and result drain per beat
// depends on lzg_pkg
`timescale 1ns / 1ps

module lzg_ctrl
  import lzg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_COPY_WR, S_COPY_LOOP, S_FINISH
  } state_t;

  state_t st_r, st_nxt;
  logic   in_ready_r;
  logic   can_step;

  assign can_step = !sts.hold_v || sts.out_free;

  always_comb begin
    cmd    = CMD_NONE;
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd    = CMD_START;
          st_nxt = sts.skip ? S_FINISH : S_RUN;
        end
      end
      S_RUN: begin
        if (can_step) begin
          if (sts.term) begin
            st_nxt = S_FINISH;
          end else if (sts.copy) begin
            if (sts.copy_nz && sts.res_ok) begin
              cmd    = CMD_RD_FIRST;
              st_nxt = S_COPY_WR;
            end else if (sts.copy_nz) begin
              st_nxt = S_FINISH;
            end else begin
              cmd = CMD_TO_CMD;
            end
          end else if (sts.brk) begin
            if (sts.ended) cmd = CMD_FAIL;
            st_nxt = S_FINISH;
          end else begin
            cmd = CMD_BIT;
          end
        end
      end
      S_COPY_WR: begin
        if (can_step) begin
          cmd    = CMD_WR;
          st_nxt = S_COPY_LOOP;
        end
      end
      S_COPY_LOOP: begin
        if (sts.copy_nz && sts.res_ok && sts.burst_ok) begin
          cmd    = CMD_RD;
          st_nxt = S_COPY_WR;
        end else if (sts.copy_nz) begin
          st_nxt = S_FINISH;
        end else begin
          cmd    = CMD_TO_CMD;
          st_nxt = S_RUN;
        end
      end
      S_FINISH: begin
        if (can_step) begin
          cmd    = CMD_FINISH;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      st_r       <= st_nxt;
      in_ready_r <= (st_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== hw/rtl/lz_gamma_stream_decompressor.sv =====
// feed beat: load the byte, then the stream bits one by one (up to 8), an end check and a drain
// copy: each byte takes a window read, a write and a loop check, at most 64 bytes a beat
// results leave through a hold stage and an output register; stalls only hold the loop
// synchronous active-low reset clears decode state; window contents stay undefined
// depends on lzg_pkg, lzg_ctrl, lzg_datapath and the assertion header
`timescale 1ns / 1ps

`include "lz_gamma_stream_decompressor_assert.svh"

module lz_gamma_stream_decompressor
  import lzg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_total_length,
  output logic              out_copy_pending,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  lzg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_byte          (in_byte),
    .in_last_byte     (in_last_byte),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_total_length (out_total_length),
    .out_copy_pending (out_copy_pending),
    .out_last         (out_last)
  );

  `LZG_ASSERT_IMP(a_idle_hold_empty, clk, rst_n, in_ready, !sts.hold_v)
  `LZG_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_status == ST_DATA || out_status == ST_END || out_status == ST_ERR)
  `LZG_ASSERT_IMP(a_pending_is_data, clk, rst_n, out_valid && out_copy_pending,
    out_status == ST_DATA)

endmodule
